// File: rtl/prnq_pkg.sv
// ============================================================================
// prnq_pkg - shared types for the point range and nearest query core
// Request kinds, result status codes and the decoded request record that
// travels from the front end through the queue to the back end.
// ============================================================================
package prnq_pkg;

    localparam int ID_W    = 64;
    localparam int COORD_W = 32;   // widest coordinate the core supports
    localparam int RAD_W   = 23;
    localparam int R2_W    = 46;
    localparam int WANT_W  = 7;
    localparam int DIST_W  = 64;

    typedef enum logic [2:0] {
        REQ_CLEAR   = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_RADIUS  = 3'd2,
        REQ_BOX     = 3'd3,
        REQ_NEAREST = 3'd4
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NONE     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    // coordinates are sign extended to COORD_W; back end uses the low bits
    typedef struct packed {
        req_kind_t                  kind;
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [COORD_W-1:0]  qx;
        logic signed [COORD_W-1:0]  qy;
        logic signed [COORD_W-1:0]  qz;
        logic [R2_W-1:0]            r2;
        logic                       search_all;
        logic [WANT_W-1:0]          want;       // already clamped to capacity
        logic                       box_bad;    // min above max on some axis
    } req_t;

endpackage

// File: rtl/prnq_front.sv
// ============================================================================
// prnq_front - request intake
// Takes input beats, drops unknown kinds, squares the radius, clamps the
// wanted count and flags inverted boxes, then hands the record to the queue.
// ============================================================================
module prnq_front #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 24,
    parameter int TD_W       = 240
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TD_W-1:0]      s_tdata,
    input  logic [2:0]           s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output prnq_pkg::req_t       q_data
);

    localparam int CB    = COORD_BITS;
    localparam int O_PX  = 64;
    localparam int O_RAD = 64 + 6 * CB;
    localparam int O_ALL = O_RAD + prnq_pkg::RAD_W;
    localparam int O_WNT = O_ALL + 1;

    logic                            f_valid_reg;
    prnq_pkg::req_t                  f_req_reg;
    prnq_pkg::req_t                  dec;
    logic                            known;
    logic                            accept;
    logic [prnq_pkg::RAD_W-1:0]      rad;
    logic [prnq_pkg::WANT_W-1:0]     want_in;

    assign s_tready = !f_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = f_valid_reg;
    assign q_data   = f_req_reg;

    always_comb
    begin
        case (s_tuser)
            prnq_pkg::REQ_CLEAR, prnq_pkg::REQ_INSERT, prnq_pkg::REQ_RADIUS,
            prnq_pkg::REQ_BOX, prnq_pkg::REQ_NEAREST: known = 1'b1;
            default:                                   known = 1'b0;
        endcase
    end

    always_comb
    begin
        rad     = s_tdata[O_RAD +: prnq_pkg::RAD_W];
        want_in = s_tdata[O_WNT +: prnq_pkg::WANT_W];
        dec.kind = prnq_pkg::req_kind_t'(s_tuser);
        dec.id   = s_tdata[63:0];
        dec.px   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX          +: CB]));
        dec.py   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX + CB     +: CB]));
        dec.pz   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX + 2 * CB +: CB]));
        dec.qx   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX + 3 * CB +: CB]));
        dec.qy   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX + 4 * CB +: CB]));
        dec.qz   = prnq_pkg::COORD_W'($signed(s_tdata[O_PX + 5 * CB +: CB]));
        dec.r2   = prnq_pkg::R2_W'(rad) * prnq_pkg::R2_W'(rad);
        dec.search_all = s_tdata[O_ALL];
        dec.want = (want_in > prnq_pkg::WANT_W'(CAPACITY)) ?
                   prnq_pkg::WANT_W'(CAPACITY) : want_in;
        dec.box_bad = (dec.px > dec.qx) || (dec.py > dec.qy) || (dec.pz > dec.qz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= known;
        end
        else if (q_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_req_reg <= dec;
        end
    end

endmodule

// File: rtl/prnq_fifo.sv
// ============================================================================
// prnq_fifo - two-entry request queue
// Decouples intake from execution so each side stalls on its own.
// ============================================================================
module prnq_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  prnq_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output prnq_pkg::req_t  out_data
);

    prnq_pkg::req_t  slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: rtl/prnq_back.sv
// ============================================================================
// prnq_back - request execution
// Owns the point store, runs the scan pipeline (read, square, sum/compare,
// act) and drives the registered result beat.
// ============================================================================
module prnq_back #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  prnq_pkg::req_t  q_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = prnq_pkg::DIST_W;

    typedef struct packed {
        logic [prnq_pkg::ID_W-1:0] id;
        logic signed [CB-1:0]      x;
        logic signed [CB-1:0]      y;
        logic signed [CB-1:0]      z;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_FINISH
    } state_t;

    entry_t                       store [CAPACITY];
    entry_t                       rd_q;

    state_t                       state_reg;
    prnq_pkg::req_t               cur_reg;
    logic [CW-1:0]                fill_reg;
    logic [CW-1:0]                idx_reg;
    logic [prnq_pkg::WANT_W-1:0]  k_reg;
    logic [CAPACITY-1:0]          picked_reg;

    logic                         held_v_reg;
    logic [63:0]                  held_id_reg;
    logic                         best_v_reg;
    logic [DW-1:0]                best_d_reg;
    logic [63:0]                  best_id_reg;
    logic [IW-1:0]                best_idx_reg;

    logic                         s1_v_reg;
    logic [IW-1:0]                s1_idx_reg;
    logic                         s2_v_reg;
    logic [IW-1:0]                s2_idx_reg;
    logic [63:0]                  s2_id_reg;
    logic [2*CB-1:0]              s2_sqx_reg;
    logic [2*CB-1:0]              s2_sqy_reg;
    logic [2*CB-1:0]              s2_sqz_reg;
    logic                         s2_box_reg;
    logic                         s2_picked_reg;
    logic                         s3_v_reg;
    logic [IW-1:0]                s3_idx_reg;
    logic [63:0]                  s3_id_reg;
    logic [DW-1:0]                s3_d_reg;
    logic                         s3_hit_reg;

    logic                         out_valid_reg;
    logic [63:0]                  out_id_reg;
    prnq_pkg::status_t            out_status_reg;
    logic                         out_last_reg;

    logic                         slot;
    logic                         issue;
    logic                         pop;
    logic                         store_we;
    logic                         scan_start;
    logic                         beat_load;
    logic signed [CB-1:0]         cx;
    logic signed [CB-1:0]         cy;
    logic signed [CB-1:0]         cz;
    logic signed [CB:0]           dx;
    logic signed [CB:0]           dy;
    logic signed [CB:0]           dz;
    logic [CB-1:0]                ax;
    logic [CB-1:0]                ay;
    logic [CB-1:0]                az;
    logic                         box_ok;
    logic [DW+1:0]                sum;
    logic [DW-1:0]                sq_dist;
    logic                         in_rad;
    logic                         hit;
    logic                         better;

    assign slot     = !out_valid_reg || m_tready;
    assign issue    = (state_reg == S_SCAN) && (idx_reg < fill_reg);
    assign q_ready  = (state_reg == S_IDLE) && slot;
    assign pop      = q_valid && q_ready;
    assign store_we = pop && (q_data.kind == prnq_pkg::REQ_INSERT) &&
                      (fill_reg != CW'(CAPACITY));

    // request that goes on to a scan instead of answering at once
    assign scan_start = pop && (fill_reg != '0) &&
                        ((q_data.kind == prnq_pkg::REQ_RADIUS) ||
                         ((q_data.kind == prnq_pkg::REQ_BOX) && !q_data.box_bad) ||
                         ((q_data.kind == prnq_pkg::REQ_NEAREST) && (q_data.want != '0)));

    // a new beat enters the result register this cycle
    assign beat_load = (pop && !scan_start) ||
                       (slot && s3_v_reg && s3_hit_reg && held_v_reg &&
                        (cur_reg.kind != prnq_pkg::REQ_NEAREST)) ||
                       ((state_reg == S_PICK) && slot && best_v_reg && held_v_reg) ||
                       ((state_reg == S_FINISH) && slot);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // store: one write port (insert), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[fill_reg[IW-1:0]] <= '{id: q_data.id, x: q_data.px[CB-1:0],
                                         y: q_data.py[CB-1:0], z: q_data.pz[CB-1:0]};
        end
        if (slot && issue)
        begin
            rd_q <= store[idx_reg[IW-1:0]];
        end
    end

    // stage 1: axis differences, squares, box test
    always_comb
    begin
        cx = $signed(cur_reg.px[CB-1:0]);
        cy = $signed(cur_reg.py[CB-1:0]);
        cz = $signed(cur_reg.pz[CB-1:0]);
        dx = (CB+1)'(rd_q.x) - (CB+1)'(cx);
        dy = (CB+1)'(rd_q.y) - (CB+1)'(cy);
        dz = (CB+1)'(rd_q.z) - (CB+1)'(cz);
        ax = dx[CB] ? CB'(-dx) : CB'(dx);
        ay = dy[CB] ? CB'(-dy) : CB'(dy);
        az = dz[CB] ? CB'(-dz) : CB'(dz);
        box_ok = (rd_q.x >= cx) && (rd_q.x <= $signed(cur_reg.qx[CB-1:0])) &&
                 (rd_q.y >= cy) && (rd_q.y <= $signed(cur_reg.qy[CB-1:0])) &&
                 (rd_q.z >= cz) && (rd_q.z <= $signed(cur_reg.qz[CB-1:0]));
    end

    // stage 2: saturating sum and match decision
    always_comb
    begin
        sum  = (DW+2)'(s2_sqx_reg) + (DW+2)'(s2_sqy_reg) + (DW+2)'(s2_sqz_reg);
        sq_dist = (|sum[DW+1:DW]) ? {DW{1'b1}} : sum[DW-1:0];
        in_rad = sq_dist <= DW'(cur_reg.r2);
        case (cur_reg.kind)
            prnq_pkg::REQ_BOX:     hit = s2_box_reg;
            prnq_pkg::REQ_NEAREST: hit = !s2_picked_reg && (cur_reg.search_all || in_rad);
            default:               hit = in_rad;
        endcase
    end

    // stage 3: best-so-far test for nearest queries (ties go to the lower id)
    assign better = !best_v_reg || (s3_d_reg < best_d_reg) ||
                    ((s3_d_reg == best_d_reg) && (s3_id_reg < best_id_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            picked_reg    <= '0;
            held_v_reg    <= 1'b0;
            best_v_reg    <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready && !beat_load)
            begin
                out_valid_reg <= 1'b0;
            end

            // scan pipeline, stalls while the result register is blocked
            if (slot)
            begin
                s1_v_reg   <= issue;
                s1_idx_reg <= idx_reg[IW-1:0];
                if (issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                s2_v_reg      <= s1_v_reg;
                s2_idx_reg    <= s1_idx_reg;
                s2_id_reg     <= rd_q.id;
                s2_sqx_reg    <= ax * ax;
                s2_sqy_reg    <= ay * ay;
                s2_sqz_reg    <= az * az;
                s2_box_reg    <= box_ok;
                s2_picked_reg <= picked_reg[s1_idx_reg];
                s3_v_reg   <= s2_v_reg;
                s3_idx_reg <= s2_idx_reg;
                s3_id_reg  <= s2_id_reg;
                s3_d_reg   <= sq_dist;
                s3_hit_reg <= hit;
                if (s3_v_reg && s3_hit_reg)
                begin
                    if (cur_reg.kind == prnq_pkg::REQ_NEAREST)
                    begin
                        if (better)
                        begin
                            best_v_reg   <= 1'b1;
                            best_d_reg   <= s3_d_reg;
                            best_id_reg  <= s3_id_reg;
                            best_idx_reg <= s3_idx_reg;
                        end
                    end
                    else
                    begin
                        // a newer hit proves the held one is not the last
                        if (held_v_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_id_reg     <= held_id_reg;
                            out_status_reg <= prnq_pkg::ST_HIT;
                            out_last_reg   <= 1'b0;
                        end
                        held_v_reg  <= 1'b1;
                        held_id_reg <= s3_id_reg;
                    end
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg    <= q_data;
                        idx_reg    <= '0;
                        best_v_reg <= 1'b0;
                        out_id_reg <= '0;
                        out_last_reg <= 1'b1;
                        case (q_data.kind)
                            prnq_pkg::REQ_CLEAR:
                            begin
                                fill_reg       <= '0;
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= prnq_pkg::ST_CLEARED;
                            end
                            prnq_pkg::REQ_INSERT:
                            begin
                                out_valid_reg <= 1'b1;
                                if (fill_reg == CW'(CAPACITY))
                                begin
                                    out_status_reg <= prnq_pkg::ST_FULL;
                                end
                                else
                                begin
                                    fill_reg       <= fill_reg + CW'(1);
                                    out_status_reg <= prnq_pkg::ST_INSERTED;
                                end
                            end
                            prnq_pkg::REQ_RADIUS, prnq_pkg::REQ_BOX:
                            begin
                                if ((fill_reg == '0) ||
                                    ((q_data.kind == prnq_pkg::REQ_BOX) && q_data.box_bad))
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= prnq_pkg::ST_NONE;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            prnq_pkg::REQ_NEAREST:
                            begin
                                if ((fill_reg == '0) || (q_data.want == '0))
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= prnq_pkg::ST_NONE;
                                end
                                else
                                begin
                                    picked_reg <= '0;
                                    k_reg      <= '0;
                                    state_reg  <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= prnq_pkg::ST_NONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (!issue && !s1_v_reg && !s2_v_reg && !s3_v_reg)
                    begin
                        state_reg <= (cur_reg.kind == prnq_pkg::REQ_NEAREST) ?
                                     S_PICK : S_FINISH;
                    end
                end
                S_PICK:
                begin
                    if (!best_v_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (slot)
                    begin
                        picked_reg[best_idx_reg] <= 1'b1;
                        k_reg <= k_reg + prnq_pkg::WANT_W'(1);
                        if (held_v_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_id_reg     <= held_id_reg;
                            out_status_reg <= prnq_pkg::ST_HIT;
                            out_last_reg   <= 1'b0;
                        end
                        held_v_reg  <= 1'b1;
                        held_id_reg <= best_id_reg;
                        best_v_reg  <= 1'b0;
                        idx_reg     <= '0;
                        if ((k_reg + prnq_pkg::WANT_W'(1)) == cur_reg.want)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (slot)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        out_id_reg     <= held_v_reg ? held_id_reg : 64'd0;
                        out_status_reg <= held_v_reg ? prnq_pkg::ST_HIT : prnq_pkg::ST_NONE;
                        held_v_reg     <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_picked_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(picked_reg) == int'(k_reg))
        else $error("picked flags disagree with emitted count");

    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |-> (!s1_v_reg && !s2_v_reg && !s3_v_reg))
        else $error("scan pipeline busy outside a scan");

    a_no_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_v_reg)
        else $error("held hit left behind after a request");

    a_mid_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_status_reg == prnq_pkg::ST_HIT))
        else $error("non-final beat that is not a hit");

endmodule

// File: rtl/point_range_and_nearest_query_core.sv
// ============================================================================
// point_range_and_nearest_query_core - point store with spatial queries
// Top level: request intake, two-entry queue and execution back end.
// ============================================================================
// Keeps up to CAPACITY points (64-bit id, signed Q15.8 x/y/z) and serves
// clear, insert, radius, box and nearest requests, one request at a time in
// the back end while the front end keeps taking beats into a short queue.
// Clear and insert produce one result beat a few cycles after acceptance.
// Radius and box queries stream their hits in insertion order, from a scan
// pipeline that reads one stored point per cycle from the single store read
// port while the result register is not blocked. A nearest query repeats
// that scan once per returned id, and once more when it returns fewer than
// want_count ids. Distances are exact squared integers; nearest ties go
// to the lower id, then the older entry. A query with no match returns one
// beat with status "no hits" and tlast. Unknown request kinds are dropped
// without a result. Stalls on m_tready freeze the scan pipeline, nothing
// is lost.
module point_range_and_nearest_query_core #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: entry_id, point_x, point_y, point_z, corner_x,
    // corner_y, corner_z, search_radius, search_all, want_count, zero pad
    input  logic [((95 + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: req_type
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: found_id
    output logic [63:0]          m_tdata,
    // m_tuser: status
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int TD_W = ((95 + 6 * COORD_BITS + 7) / 8) * 8;

    logic            f_valid;
    logic            f_ready;
    prnq_pkg::req_t  f_data;
    logic            b_valid;
    logic            b_ready;
    prnq_pkg::req_t  b_data;

    prnq_front #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .TD_W       (TD_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    prnq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    prnq_back #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_data   (b_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/prnq_checker.sv
// ============================================================================
// prnq_checker - result predictor and scoreboard for the point query core
// Watches both stream channels, keeps its own copy of the point store,
// predicts the result beats of every accepted request and compares them.
// ============================================================================
module prnq_checker #(
    parameter int CAPACITY = 64,
    parameter int TDATA_W  = 240
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [2:0]         s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [63:0]        m_tdata,
    input  logic [2:0]         m_tuser,
    input  logic               m_tlast,
    output int                 fail_count,
    output int                 pending_beats,
    output int                 hit_beats
);

    typedef struct packed {
        logic [63:0]         id;
        prnq_pkg::status_t   st;
        logic                last;
    } result_t;

    result_t             want_q[$];
    logic [63:0]         pt_id[CAPACITY];
    logic signed [23:0]  pt_x[CAPACITY];
    logic signed [23:0]  pt_y[CAPACITY];
    logic signed [23:0]  pt_z[CAPACITY];
    int                  fill;

    assign pending_beats = want_q.size();

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [63:0] sqdist(int i, logic signed [23:0] cx,
                                           logic signed [23:0] cy,
                                           logic signed [23:0] cz);
        logic signed [63:0] dx, dy, dz;
        dx = 64'(pt_x[i]) - 64'(cx);
        dy = 64'(pt_y[i]) - 64'(cy);
        dz = 64'(pt_z[i]) - 64'(cz);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic push(logic [63:0] id, prnq_pkg::status_t st);
        result_t r;
        r.id = id; r.st = st; r.last = 1'b0;
        want_q = {want_q, r};
    endtask

    // mark the final beat of a query, or add the "no hits" beat
    task automatic close_query(int n);
        if (n == 0) push(64'd0, prnq_pkg::ST_NONE);
        want_q[want_q.size() - 1].last = 1'b1;
    endtask

    task automatic predict_request(logic [2:0] kind, logic [TDATA_W-1:0] d);
        logic [63:0]        eid;
        logic signed [23:0] px, py, pz, qx, qy, qz;
        logic [63:0]        r2, dd, bd;
        logic               all_pts, have;
        int                 want, n, best;
        bit                 picked[CAPACITY];
        eid = d[63:0];
        px = d[87:64];   py = d[111:88];  pz = d[135:112];
        qx = d[159:136]; qy = d[183:160]; qz = d[207:184];
        r2 = 64'(d[230:208]) * 64'(d[230:208]);
        all_pts = d[231];
        want = int'(d[238:232]);
        n = 0;
        case (kind)
            prnq_pkg::REQ_CLEAR:
            begin
                fill = 0;
                push(64'd0, prnq_pkg::ST_CLEARED);
                close_query(1);
            end
            prnq_pkg::REQ_INSERT:
            begin
                if (fill >= CAPACITY) push(64'd0, prnq_pkg::ST_FULL);
                else
                begin
                    pt_id[fill] = eid; pt_x[fill] = px;
                    pt_y[fill] = py; pt_z[fill] = pz;
                    fill++;
                    push(64'd0, prnq_pkg::ST_INSERTED);
                end
                close_query(1);
            end
            prnq_pkg::REQ_RADIUS:
            begin
                for (int i = 0; i < fill; i++)
                    if (sqdist(i, px, py, pz) <= r2)
                    begin
                        push(pt_id[i], prnq_pkg::ST_HIT); n++;
                    end
                close_query(n);
            end
            prnq_pkg::REQ_BOX:
            begin
                if (px <= qx && py <= qy && pz <= qz)
                    for (int i = 0; i < fill; i++)
                        if (pt_x[i] >= px && pt_x[i] <= qx && pt_y[i] >= py &&
                            pt_y[i] <= qy && pt_z[i] >= pz && pt_z[i] <= qz)
                        begin
                            push(pt_id[i], prnq_pkg::ST_HIT); n++;
                        end
                close_query(n);
            end
            prnq_pkg::REQ_NEAREST:
            begin
                if (want > CAPACITY) want = CAPACITY;
                foreach (picked[i]) picked[i] = 0;
                while (n < want)
                begin
                    have = 0; best = 0; bd = 0;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (picked[i]) continue;
                        dd = sqdist(i, px, py, pz);
                        if (!all_pts && dd > r2) continue;
                        if (!have || dd < bd || (dd == bd && pt_id[i] < pt_id[best]))
                        begin
                            have = 1; best = i; bd = dd;
                        end
                    end
                    if (!have) break;
                    picked[best] = 1;
                    push(pt_id[best], prnq_pkg::ST_HIT); n++;
                end
                close_query(n);
            end
            default: ;  // unknown kinds produce nothing
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            want_q.delete();
            fill = 0;
            fail_count = 0;
            hit_beats = 0;
        end
        else
        begin
            // results are checked before the new request is predicted: a
            // request cannot produce a beat in the cycle it is accepted
            if (m_tvalid && m_tready)
            begin
                if (m_tuser == prnq_pkg::ST_HIT) hit_beats++;
                if (want_q.size() == 0)
                    report($sformatf("unexpected beat id=%h st=%0d", m_tdata, m_tuser));
                else
                begin
                    exp_r = want_q.pop_front();
                    if (m_tdata !== exp_r.id)
                        report($sformatf("id %h, expected %h", m_tdata, exp_r.id));
                    if (m_tuser !== exp_r.st)
                        report($sformatf("status %0d, expected %0d", m_tuser, exp_r.st));
                    if (m_tlast !== exp_r.last)
                        report($sformatf("tlast %b, expected %b", m_tlast, exp_r.last));
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
        end
    end

endmodule

// File: tb/tb.sv
// ============================================================================
// tb - stimulus and verdict for the point range and nearest query core
// Drives directed and random request beats in bursts, stalls the result
// side in random phases, and leaves prediction and checking to prnq_checker.
// ============================================================================
module tb;

    localparam int CAPACITY = 64;
    localparam int TDATA_W  = 240;
    localparam int IDLE_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [2:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;
    int                 fail_count, pending_beats, hit_beats;
    int                 idle_cycles = 0;
    int                 stall_mode = 0;
    int                 sent = 0;
    int                 fill_est = 0;

    always #6 clk = ~clk;

    point_range_and_nearest_query_core #(.CAPACITY(CAPACITY), .COORD_BITS(24)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    prnq_checker #(.CAPACITY(CAPACITY), .TDATA_W(TDATA_W)) u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_beats(pending_beats), .hit_beats(hit_beats)
    );

    // receiver: phases of always-ready, light and heavy stalling
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d beats still expected", pending_beats);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // random coordinate: mostly a small cluster so queries hit, some extremes
    function automatic logic [23:0] rnd_coord();
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [TDATA_W-1:0] pack_req(logic [63:0] eid,
        logic [23:0] px, logic [23:0] py, logic [23:0] pz,
        logic [23:0] qx, logic [23:0] qy, logic [23:0] qz,
        logic [22:0] rad, logic all_pts, logic [6:0] want);
        return {1'b0, want, all_pts, rad, qz, qy, qx, pz, py, px, eid};
    endfunction

    // hold one beat until it is taken; optional gap afterwards
    task automatic send(logic [2:0] kind, logic [TDATA_W-1:0] d);
        s_tuser  <= kind;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        sent++;
        if (kind == prnq_pkg::REQ_CLEAR) fill_est = 0;
        if (kind == prnq_pkg::REQ_INSERT && fill_est < CAPACITY) fill_est++;
    endtask

    task automatic gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_random();
        logic [2:0]  kind;
        logic [63:0] eid;
        logic [22:0] rad;
        logic [23:0] px, py, pz;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)       kind = prnq_pkg::REQ_CLEAR;
        else if (pick < 4)  kind = 3'($urandom_range(5, 7));
        else if (pick < 45) kind = prnq_pkg::REQ_INSERT;
        else if (pick < 63) kind = prnq_pkg::REQ_RADIUS;
        else if (pick < 80) kind = prnq_pkg::REQ_BOX;
        else                kind = prnq_pkg::REQ_NEAREST;
        eid = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) eid = 64'($urandom_range(0, 7));  // duplicates
        rad = ($urandom_range(0, 4) == 0) ? 23'($urandom) : 23'($urandom_range(0, 3000));
        px = rnd_coord(); py = rnd_coord(); pz = rnd_coord();
        send(kind, pack_req(eid, px, py, pz,
                            24'($signed(px) + $urandom_range(0, 3000) - 200),
                            24'($signed(py) + $urandom_range(0, 3000) - 200),
                            24'($signed(pz) + $urandom_range(0, 3000) - 200),
                            rad, ($urandom_range(0, 2) == 0),
                            ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                                                          7'($urandom_range(0, 8))));
    endtask

    initial
    begin
        int burst;
        int tail;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty-store queries, extremes, ties, inverted box, full store
        send(prnq_pkg::REQ_RADIUS, pack_req(0, 0, 0, 0, 0, 0, 0, 23'h7FFFFF, 0, 5));
        send(prnq_pkg::REQ_NEAREST, pack_req(0, 0, 0, 0, 0, 0, 0, 23'h7FFFFF, 1, 5));
        send(prnq_pkg::REQ_INSERT, pack_req(64'hFFFF_FFFF_FFFF_FFFF, 24'h7FFFFF,
                                            24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_INSERT, pack_req(64'd0, 24'h800000, 24'h800000, 24'h800000,
                                            0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_INSERT, pack_req(64'd5, 24'd100, 0, 0, 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_INSERT, pack_req(64'd3, 24'hFFFF9C, 0, 0, 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_INSERT, pack_req(64'd3, 0, 24'd100, 0, 0, 0, 0, 0, 0, 0));
        send(3'd6, pack_req(64'd9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_RADIUS, pack_req(0, 0, 0, 0, 0, 0, 0, 23'd100, 0, 0));
        send(prnq_pkg::REQ_RADIUS, pack_req(0, 0, 0, 0, 0, 0, 0, 23'h7FFFFF, 0, 0));
        send(prnq_pkg::REQ_RADIUS, pack_req(0, 0, 0, 0, 0, 0, 0, 23'd99, 0, 0));
        send(prnq_pkg::REQ_BOX, pack_req(0, 24'h800000, 24'h800000, 24'h800000,
                                         24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0));
        send(prnq_pkg::REQ_BOX, pack_req(0, 24'd10, 0, 0, 24'd9, 24'd5, 24'd5, 0, 0, 0));
        send(prnq_pkg::REQ_NEAREST, pack_req(0, 0, 0, 0, 0, 0, 0, 23'd100, 0, 7'd64));
        send(prnq_pkg::REQ_NEAREST, pack_req(0, 0, 0, 0, 0, 0, 0, 0, 1, 7'd127));
        send(prnq_pkg::REQ_NEAREST, pack_req(0, 0, 0, 0, 0, 0, 0, 23'd100, 0, 7'd0));
        send(prnq_pkg::REQ_CLEAR, '0);
        // fill to capacity, then overflow
        while (fill_est < CAPACITY)
            send(prnq_pkg::REQ_INSERT, pack_req(64'($urandom_range(0, 20)), rnd_coord(),
                                                rnd_coord(), rnd_coord(), 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_INSERT, pack_req(64'd77, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(prnq_pkg::REQ_NEAREST, pack_req(0, 0, 0, 0, 0, 0, 0, 0, 1, 7'd64));
        send(prnq_pkg::REQ_CLEAR, '0);

        // random bursts
        for (int k = 0; k < 270;)
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++, k++) send_random();
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 20));
        end
        s_tvalid <= 1'b0;

        tail = 0;
        while (pending_beats != 0) @(posedge clk);
        while (tail < 50)
        begin
            @(posedge clk);
            tail++;
        end

        $display("Sent %0d request beats, including clear, insert, full-store drops,", sent);
        $display("radius, box and nearest queries; %0d hit beats checked.", hit_beats);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
